>>> rtl/core/pts_pkg.sv
// Shared types and constants for the preemptive tick scheduler.
// Depends on nothing; the cells, the top level and the checker import it.
package pts_pkg;

    localparam int DATA_W = 16;
    localparam int PRIO_W = 8;
    localparam int ID_W   = 5;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic KEY_PRIORITY  = 1'b0;
    localparam logic KEY_REMAINING = 1'b1;

    localparam logic [DATA_W-1:0] TIME_MAX = '1;

    typedef enum logic [1:0] {
        STAT_LOADED    = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_IDLE_TICK = 2'd2,
        STAT_RAN       = 2'd3
    } status_t;

    // Best candidate seen so far as the scan wave moves down the chain.
    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] arrival;
        logic [DATA_W-1:0] burst;
        logic [DATA_W-1:0] remaining;
        logic [PRIO_W-1:0] prio;
    } cand_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              wr_en;
        logic              dec_en;
        logic              select_key;
        logic [DATA_W-1:0] clock_time;
        logic [DATA_W-1:0] arrival;
        logic [DATA_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } cell_ctrl_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   task_id;
        logic              finished;
        logic [DATA_W-1:0] turnaround;
        logic [DATA_W-1:0] waiting;
    } res_t;

endpackage

>>> rtl/core/pts_if.sv
// Valid/ready channel interfaces for the scheduler's input and result items.
// Payload widths match pts_pkg; no dependencies otherwise.
interface pts_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  task_priority;

    modport source (output valid, mode, arrival_time, burst_length, task_priority,
                    input ready);
    modport sink   (input valid, mode, arrival_time, burst_length, task_priority,
                    output ready);
endinterface

interface pts_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  task_id;
    logic        finished;
    logic [15:0] time_now;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;

    modport source (output valid, status, task_id, finished, time_now, turnaround,
                    waiting, all_done, input ready);
    modport sink   (input valid, status, task_id, finished, time_now, turnaround,
                    waiting, all_done, output ready);
endinterface

>>> rtl/core/pts_cell.sv
// One task slot of the scheduler chain: stores the task and merges it into
// the candidate wave passing from its left neighbor. Depends on pts_pkg.
module pts_cell #(
    parameter int IDX    = 0,
    parameter int SLOT_W = 4,
    parameter int CNT_W  = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pts_pkg::cell_ctrl_t      ctrl,
    input  logic [SLOT_W-1:0]        wr_slot,
    input  logic [SLOT_W-1:0]        dec_slot,
    input  logic [CNT_W-1:0]         task_count,
    input  logic                     go_in,
    input  pts_pkg::cand_t           cand_in,
    input  logic [SLOT_W-1:0]        slot_in,
    output logic                     go_out,
    output pts_pkg::cand_t           cand_out,
    output logic [SLOT_W-1:0]        slot_out
);
    import pts_pkg::*;

    localparam logic [CNT_W-1:0]  MY_CNT  = CNT_W'(IDX);
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    logic [DATA_W-1:0] arrival_reg;
    logic [DATA_W-1:0] burst_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic              go_reg;
    cand_t             cand_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic  eligible;
    logic  better;
    logic  take;
    cand_t own;

    always_comb
    begin
        own.found     = 1'b1;
        own.arrival   = arrival_reg;
        own.burst     = burst_reg;
        own.remaining = rem_reg;
        own.prio      = prio_reg;
        eligible = (MY_CNT < task_count) && (arrival_reg <= ctrl.clock_time)
                   && (rem_reg != '0);
        // A later slot only wins on a strictly smaller key.
        if (ctrl.select_key == KEY_REMAINING)
            better = rem_reg < cand_in.remaining;
        else if (prio_reg != cand_in.prio)
            better = prio_reg < cand_in.prio;
        else
            better = arrival_reg < cand_in.arrival;
        take = eligible && (!cand_in.found || better);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            go_reg <= 1'b0;
        else
            go_reg <= go_in;
    end

    always_ff @(posedge clk)
    begin
        if (go_in)
        begin
            cand_reg <= take ? own : cand_in;
            slot_reg <= take ? MY_SLOT : slot_in;
        end
        if (ctrl.wr_en && (wr_slot == MY_SLOT))
        begin
            arrival_reg <= ctrl.arrival;
            burst_reg   <= ctrl.burst;
            rem_reg     <= ctrl.burst;
            prio_reg    <= ctrl.prio;
        end
        else if (ctrl.dec_en && (dec_slot == MY_SLOT))
        begin
            rem_reg <= rem_reg - 1'b1;
        end
    end

    assign go_out   = go_reg;
    assign cand_out = cand_reg;
    assign slot_out = slot_reg;

endmodule

>>> rtl/core/preemptive_tick_scheduler.sv
// Top level of the preemptive tick scheduler: sequencer, counters and the
// chain of task cells. Depends on pts_pkg, pts_if and pts_cell.
//
// Usage. Items arrive on in_ch (valid/ready). A load item (mode 0) stores a
// task in the next free slot and returns status "loaded" with its id, or
// "full" when every slot is taken. A tick item (mode 1) runs the eligible task
// with the least key for one time unit and advances the saturating clock;
// select_key (written through cfg_we/cfg_wdata while idle) chooses between
// priority order and shortest remaining time. One result item per input item
// leaves on out_ch.
// Sequence: a load is written to res_reg at the accepting edge and moves on to
// the result register from S_FIN; a tick runs the candidate wave that walks
// the cell chain one slot per cycle from the accepting edge, followed by the
// pick capture, the run with the turnaround subtraction, the waiting
// subtraction and the result register load.
// The block works on one item at a time and takes no new item until the last
// one has been moved into the result register.
// The result register frees the input side: a new item is taken while a
// finished result waits; if the receiver stalls longer, the next result
// holds in the sequencer and in_ch.ready stays low until the register frees.
// Reset empties the table, zeroes the clock and the counters, clears the
// result valid flag and selects priority order.
module preemptive_tick_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    pts_in_if.sink    in_ch,
    pts_out_if.source out_ch
);
    import pts_pkg::*;

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_TAT  = 5'b00100,
        S_WAIT = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  task_count_reg, task_count_next;
    logic [CNT_W-1:0]  done_count_reg, done_count_next;
    logic [DATA_W-1:0] clock_reg, clock_next;
    logic              select_key_reg;
    res_t              res_reg, res_next;
    cand_t             pick_reg, pick_next;
    logic [SLOT_W-1:0] pick_slot_reg, pick_slot_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg, out_res_next;
    logic [DATA_W-1:0] out_time_reg, out_time_next;
    logic              out_done_reg, out_done_next;

    // The chain: index 0 is the wave's entry, index MAX_TASKS its exit.
    logic              go_w   [0:MAX_TASKS];
    cand_t             cand_w [0:MAX_TASKS];
    logic [SLOT_W-1:0] slot_w [0:MAX_TASKS];

    cell_ctrl_t        ctrl;
    logic              in_acc;
    logic              full;
    logic [CNT_W:0]    load_id_wide;
    logic [SLOT_W:0]   run_id_wide;
    logic [DATA_W-1:0] clock_inc;
    logic              pick_fin;

    assign in_acc       = in_ch.valid && in_ch.ready;
    assign full         = (task_count_reg == FULL_CNT);
    assign load_id_wide = {1'b0, task_count_reg} + 1'b1;
    assign run_id_wide  = {1'b0, pick_slot_reg} + 1'b1;
    assign clock_inc    = (clock_reg != TIME_MAX) ? clock_reg + 1'b1 : clock_reg;
    assign pick_fin     = (pick_reg.remaining == DATA_W'(1));

    // A burst of zero is stored as one.
    always_comb
    begin
        ctrl.wr_en      = (state_reg == S_IDLE) && in_acc && (in_ch.mode == MODE_LOAD) && !full;
        ctrl.dec_en     = (state_reg == S_TAT) && pick_reg.found;
        ctrl.select_key = select_key_reg;
        ctrl.clock_time = clock_reg;
        ctrl.arrival    = in_ch.arrival_time;
        ctrl.burst      = (in_ch.burst_length == '0) ? DATA_W'(1) : in_ch.burst_length;
        ctrl.prio       = in_ch.task_priority;
    end

    // The wave enters the first cell with no candidate in hand.
    assign go_w[0]   = (state_reg == S_IDLE) && in_acc && (in_ch.mode == MODE_TICK);
    assign cand_w[0] = '0;
    assign slot_w[0] = '0;

    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_cell
        pts_cell #(
            .IDX    (g),
            .SLOT_W (SLOT_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .wr_slot    (task_count_reg[SLOT_W-1:0]),
            .dec_slot   (pick_slot_reg),
            .task_count (task_count_reg),
            .go_in      (go_w[g]),
            .cand_in    (cand_w[g]),
            .slot_in    (slot_w[g]),
            .go_out     (go_w[g+1]),
            .cand_out   (cand_w[g+1]),
            .slot_out   (slot_w[g+1])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        task_count_next = task_count_reg;
        done_count_next = done_count_reg;
        clock_next      = clock_reg;
        res_next        = res_reg;
        pick_next       = pick_reg;
        pick_slot_next  = pick_slot_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        out_time_next   = out_time_reg;
        out_done_next   = out_done_reg;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.mode == MODE_LOAD)
                    begin
                        res_next = '0;
                        if (full)
                        begin
                            res_next.status = STAT_FULL;
                        end
                        else
                        begin
                            res_next.status  = STAT_LOADED;
                            res_next.task_id = ID_W'(load_id_wide);
                            task_count_next  = task_count_reg + 1'b1;
                        end
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (go_w[MAX_TASKS])
                begin
                    pick_next      = cand_w[MAX_TASKS];
                    pick_slot_next = slot_w[MAX_TASKS];
                    state_next     = S_TAT;
                end
            end
            S_TAT:
            begin
                // The chosen cell decrements its remaining time at this edge.
                clock_next = clock_inc;
                res_next   = '0;
                if (pick_reg.found)
                begin
                    res_next.status   = STAT_RAN;
                    res_next.task_id  = ID_W'(run_id_wide);
                    res_next.finished = pick_fin;
                    if (pick_fin)
                        res_next.turnaround = clock_inc - pick_reg.arrival;
                end
                else
                begin
                    res_next.status = STAT_IDLE_TICK;
                end
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (res_reg.finished)
                begin
                    done_count_next = done_count_reg + 1'b1;
                    // Only after the clock has saturated can this go negative.
                    if (res_reg.turnaround >= pick_reg.burst)
                        res_next.waiting = res_reg.turnaround - pick_reg.burst;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_time_next  = clock_reg;
                    out_done_next  = (done_count_reg == task_count_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            task_count_reg <= '0;
            done_count_reg <= '0;
            clock_reg      <= '0;
            select_key_reg <= KEY_PRIORITY;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            task_count_reg <= task_count_next;
            done_count_reg <= done_count_next;
            clock_reg      <= clock_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
                select_key_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        pick_reg      <= pick_next;
        pick_slot_reg <= pick_slot_next;
        out_res_reg   <= out_res_next;
        out_time_reg  <= out_time_next;
        out_done_reg  <= out_done_next;
    end

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_res_reg.status;
    assign out_ch.task_id    = out_res_reg.task_id;
    assign out_ch.finished   = out_res_reg.finished;
    assign out_ch.time_now   = out_time_reg;
    assign out_ch.turnaround = out_res_reg.turnaround;
    assign out_ch.waiting    = out_res_reg.waiting;
    assign out_ch.all_done   = out_done_reg;

endmodule

>>> rtl/core/pts_checker.sv
// Port-level checks on the scheduler's result channel, bound to the top
// level. Depends on pts_pkg and preemptive_tick_scheduler.
module pts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [4:0]  task_id,
    input logic        finished,
    input logic [15:0] turnaround,
    input logic [15:0] waiting
);
    import pts_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_load_no_times: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_LOADED || status == STAT_FULL)
        |-> !finished && turnaround == '0 && waiting == '0)
        else $error("load result carries run data");

    a_idle_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_IDLE_TICK || status == STAT_FULL)
        |-> task_id == '0 && !finished)
        else $error("idle or rejected result names a task");

    a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> status == STAT_RAN && task_id != '0)
        else $error("finished flag on a result that ran no task");

    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> waiting <= turnaround)
        else $error("waiting time exceeds turnaround");

endmodule

bind preemptive_tick_scheduler pts_checker u_pts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .task_id    (out_ch.task_id),
    .finished   (out_ch.finished),
    .turnaround (out_ch.turnaround),
    .waiting    (out_ch.waiting)
);

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for preemptive_tick_scheduler: directed and random load/tick items,
// each result checked against a cycle-free model of the task table kept in this file.
// Depends on pts_pkg, pts_if (pts_in_if, pts_out_if) and the scheduler RTL.
module tb;

    import pts_pkg::*;

    localparam int MAX_TASKS      = 16;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;
    // Items sent at the end of the run with neither side idling.
    localparam int NO_IDLE_ITEMS  = 60;

    // One input item as the sender drives it.
    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] arrival;
        logic [DATA_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } sched_item_t;

    // One result item as the block returns it.
    typedef struct {
        status_t           status;
        logic [ID_W-1:0]   task_id;
        logic              finished;
        logic [DATA_W-1:0] time_now;
        logic [DATA_W-1:0] turnaround;
        logic [DATA_W-1:0] waiting;
        logic              all_done;
    } sched_result_t;

    // One slot of the task table as the model keeps it.
    typedef struct packed {
        logic [DATA_W-1:0] arrival;
        logic [DATA_W-1:0] burst;
        logic [DATA_W-1:0] remaining;
        logic [PRIO_W-1:0] prio;
    } task_slot_t;

    // A row of the directed plan; the expected result is only filled in where it is obvious.
    typedef struct {
        sched_item_t   item;
        bit            typed;
        sched_result_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    pts_in_if  in_ch ();
    pts_out_if out_ch ();

    preemptive_tick_scheduler #(
        .MAX_TASKS (MAX_TASKS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Model state: the task table, its counters, the clock and the selection key.
    task_slot_t        task_tbl [MAX_TASKS];
    int unsigned       n_loaded;
    int unsigned       n_done;
    logic [DATA_W-1:0] now_t;
    logic              key_sel;

    sched_result_t pending_results[$];
    plan_row_t     directed_plan[$];
    int            mismatches;

    // Handshake shaping for the sender and the receiver.
    bit long_hold_req;
    bit no_idle;
    int burst_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // True when slot a should be chosen over slot b, where b was seen earlier in the scan.
    // A strict compare keeps every tie with the lower slot.
    function automatic bit outranks(input int a, input int b);
        if (key_sel == KEY_REMAINING)
            return task_tbl[a].remaining < task_tbl[b].remaining;
        if (task_tbl[a].prio != task_tbl[b].prio)
            return task_tbl[a].prio < task_tbl[b].prio;
        return task_tbl[a].arrival < task_tbl[b].arrival;
    endfunction

    // Applies one accepted item to the model table and returns the result it must produce.
    function automatic sched_result_t schedule_step(input sched_item_t it);
        sched_result_t     r;
        bit                found;
        int                pick;
        int                i;
        logic [DATA_W-1:0] b;
        r.status     = STAT_LOADED;
        r.task_id    = '0;
        r.finished   = 1'b0;
        r.turnaround = '0;
        r.waiting    = '0;
        found        = 1'b0;
        pick         = 0;
        if (it.mode == MODE_LOAD)
        begin
            if (n_loaded < MAX_TASKS)
            begin
                // A zero burst is stored as one unit of work.
                b = (it.burst == '0) ? DATA_W'(1) : it.burst;
                task_tbl[n_loaded].arrival   = it.arrival;
                task_tbl[n_loaded].burst     = b;
                task_tbl[n_loaded].remaining = b;
                task_tbl[n_loaded].prio      = it.prio;
                n_loaded++;
                r.task_id = ID_W'(n_loaded);
            end
            else
            begin
                r.status = STAT_FULL;
            end
        end
        else
        begin
            for (i = 0; i < n_loaded; i++)
            begin
                if (task_tbl[i].arrival > now_t || task_tbl[i].remaining == '0)
                    continue;
                if (!found || outranks(i, pick))
                begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            if (now_t != TIME_MAX)
                now_t++;
            if (!found)
            begin
                r.status = STAT_IDLE_TICK;
            end
            else
            begin
                r.status = STAT_RAN;
                r.task_id = ID_W'(pick + 1);
                task_tbl[pick].remaining--;
                if (task_tbl[pick].remaining == '0)
                begin
                    r.finished   = 1'b1;
                    n_done++;
                    r.turnaround = now_t - task_tbl[pick].arrival;
                    // Once the clock has stuck at its top the waiting time would go
                    // negative; it is clamped to zero instead.
                    r.waiting = (r.turnaround >= task_tbl[pick].burst) ?
                                r.turnaround - task_tbl[pick].burst : '0;
                end
            end
        end
        r.time_now = now_t;
        r.all_done = (n_done == n_loaded);
        return r;
    endfunction

    function automatic sched_result_t outcome(input status_t s, input int id, input bit fin,
                                              input int tnow, input int tat, input int wt,
                                              input bit alld);
        sched_result_t r;
        r.status     = s;
        r.task_id    = ID_W'(id);
        r.finished   = fin;
        r.time_now   = DATA_W'(tnow);
        r.turnaround = DATA_W'(tat);
        r.waiting    = DATA_W'(wt);
        r.all_done   = alld;
        return r;
    endfunction

    function automatic sched_item_t make_item(input logic m, input int arr, input int bl,
                                              input int pr);
        sched_item_t it;
        it.mode    = m;
        it.arrival = DATA_W'(arr);
        it.burst   = DATA_W'(bl);
        it.prio    = PRIO_W'(pr);
        return it;
    endfunction

    task automatic plan_row(input sched_item_t it);
        plan_row_t row;
        row.item  = it;
        row.typed = 1'b0;
        row.want  = outcome(STAT_LOADED, 0, 0, 0, 0, 0, 0);
        directed_plan.push_back(row);
    endtask

    task automatic plan_checked(input sched_item_t it, input sched_result_t want);
        plan_row_t row;
        row.item  = it;
        row.typed = 1'b1;
        row.want  = want;
        directed_plan.push_back(row);
    endtask

    // A tick item; its load fields are ignored by the block, so they carry random noise.
    function automatic sched_item_t random_tick();
        return make_item(MODE_TICK, $urandom, $urandom, $urandom);
    endfunction

    // The next load item. Ordinary tasks arrive close to the current time with mostly short
    // bursts and a narrow spread of priorities, so that ties and preemption happen often.
    // The last two free slots take the late tasks that only run once the clock is near its
    // top; once the table is full every load is rejected and carries fully random fields.
    function automatic sched_item_t next_load();
        int arr;
        int bl;
        int pr;
        if (n_loaded < MAX_TASKS - 2)
        begin
            arr = now_t + $urandom_range(0, 20);
            bl  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 150);
            pr  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
            return make_item(MODE_LOAD, arr, bl, pr);
        end
        if (n_loaded == MAX_TASKS - 2)
            return make_item(MODE_LOAD, 65400, 300, 254);
        if (n_loaded == MAX_TASKS - 1)
            return make_item(MODE_LOAD, 65535, 65535, 255);
        return make_item(MODE_LOAD, $urandom, $urandom, $urandom);
    endfunction

    // Offers one item, starting at a falling edge, and returns at the rising edge where it is
    // taken. The sender works in bursts with random gaps between them; valid is only lowered
    // for a gap, never between two items of one burst.
    task automatic offer_item(input sched_item_t it);
        int gap;
        @(negedge clk);
        if (burst_left <= 0 && !no_idle)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 20);
        end
        in_ch.valid         = 1'b1;
        in_ch.mode          = it.mode;
        in_ch.arrival_time  = it.arrival;
        in_ch.burst_length  = it.burst;
        in_ch.task_priority = it.prio;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        burst_left--;
    endtask

    task automatic issue(input sched_item_t it);
        offer_item(it);
        pending_results.push_back(schedule_step(it));
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Register write, only done with the block idle; called at a falling edge.
    task automatic write_key(input logic k);
        cfg_we    = 1'b1;
        cfg_wdata = k;
        @(negedge clk);
        cfg_we  = 1'b0;
        key_sel = k;
    endtask

    // Result receiver. It alternates ready stretches with stalls of random length, sometimes
    // with no stall at all. On request it holds ready low for a long counted stretch so the
    // block backs up and stops taking items.
    initial
    begin : result_sink
        int run_len;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                out_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (no_idle)
            begin
                out_ch.ready = 1'b1;
                @(negedge clk);
            end
            else
            begin
                out_ch.ready = 1'b1;
                run_len = $urandom_range(1, 40);
                repeat (run_len) @(negedge clk);
                run_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                if (run_len > 0)
                begin
                    out_ch.ready = 1'b0;
                    repeat (run_len) @(negedge clk);
                end
            end
        end
    end

    task automatic log_mismatch(input string why, input sched_result_t want,
                                input sched_result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t %s: expected st=%0d id=%0d fin=%0d t=%0d tat=%0d wt=%0d done=%0d",
                     $realtime, why, want.status, want.task_id, want.finished, want.time_now,
                     want.turnaround, want.waiting, want.all_done);
            $display("    got st=%0d id=%0d fin=%0d t=%0d tat=%0d wt=%0d done=%0d",
                     got.status, got.task_id, got.finished, got.time_now, got.turnaround,
                     got.waiting, got.all_done);
        end
    endtask

    // Every result taken from the block is compared field by field with the oldest
    // expectation.
    always @(posedge clk)
    begin : result_check
        sched_result_t got;
        sched_result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.status     = status_t'(out_ch.status);
            got.task_id    = out_ch.task_id;
            got.finished   = out_ch.finished;
            got.time_now   = out_ch.time_now;
            got.turnaround = out_ch.turnaround;
            got.waiting    = out_ch.waiting;
            got.all_done   = out_ch.all_done;
            if (pending_results.size() == 0)
            begin
                want = outcome(STAT_LOADED, 0, 0, 0, 0, 0, 0);
                log_mismatch("result with nothing expected", want, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.status || got.task_id !== want.task_id ||
                    got.finished !== want.finished || got.time_now !== want.time_now ||
                    got.turnaround !== want.turnaround || got.waiting !== want.waiting ||
                    got.all_done !== want.all_done)
                    log_mismatch("result mismatch", want, got);
            end
        end
    end

    // Ends the run when neither side has moved an item for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        sched_item_t it;
        int          sent;
        int          phase;
        int          n_in_phase;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.mode          = MODE_LOAD;
        in_ch.arrival_time  = '0;
        in_ch.burst_length  = '0;
        in_ch.task_priority = '0;
        long_hold_req       = 1'b0;
        no_idle             = 1'b0;
        burst_left          = 0;
        mismatches          = 0;
        n_loaded            = 0;
        n_done              = 0;
        now_t               = '0;
        key_sel             = KEY_PRIORITY;

        // Directed part, in priority order as reset leaves it. An idle tick on the empty
        // table, a zero burst with the lowest arrival and priority, then a group of tasks
        // that tie on priority and arrival and a late arrival with priority zero that
        // preempts them. The ticks in between follow the model.
        plan_checked(make_item(MODE_TICK, 0, 0, 0),
                     outcome(STAT_IDLE_TICK, 0, 0, 1, 0, 0, 1));
        plan_checked(make_item(MODE_LOAD, 0, 0, 0),
                     outcome(STAT_LOADED, 1, 0, 1, 0, 0, 0));
        plan_checked(make_item(MODE_TICK, 0, 0, 0),
                     outcome(STAT_RAN, 1, 1, 2, 2, 1, 1));
        plan_checked(make_item(MODE_LOAD, 2, 3, 255),
                     outcome(STAT_LOADED, 2, 0, 2, 0, 0, 0));
        plan_checked(make_item(MODE_LOAD, 2, 2, 7),
                     outcome(STAT_LOADED, 3, 0, 2, 0, 0, 0));
        plan_checked(make_item(MODE_LOAD, 1, 2, 7),
                     outcome(STAT_LOADED, 4, 0, 2, 0, 0, 0));
        plan_checked(make_item(MODE_LOAD, 1, 2, 7),
                     outcome(STAT_LOADED, 5, 0, 2, 0, 0, 0));
        plan_checked(make_item(MODE_LOAD, 9, 1, 0),
                     outcome(STAT_LOADED, 6, 0, 2, 0, 0, 0));
        repeat (10) plan_row(make_item(MODE_TICK, 65535, 65535, 255));
        // Ten units of work from time 2 leave the table empty by time 12.
        plan_checked(make_item(MODE_TICK, 0, 0, 0),
                     outcome(STAT_IDLE_TICK, 0, 0, 13, 0, 0, 1));

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_plan[k])
        begin
            offer_item(directed_plan[k].item);
            it = directed_plan[k].item;
            if (directed_plan[k].typed)
            begin
                void'(schedule_step(it));
                pending_results.push_back(directed_plan[k].want);
            end
            else
            begin
                pending_results.push_back(schedule_step(it));
            end
        end

        // Random part in phases. Between phases the sender waits for every result and the
        // key is rewritten: shortest remaining first, then priority, then at random. In the
        // second phase the receiver also holds off for a long stretch.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            if (phase == 0)
                write_key(KEY_REMAINING);
            else if (phase == 1)
                write_key(KEY_PRIORITY);
            else
                write_key(1'($urandom_range(0, 1)));
            if (phase == 1)
                long_hold_req = 1'b1;
            n_in_phase = $urandom_range(80, 220);
            repeat (n_in_phase)
            begin
                if ($urandom_range(0, 99) < 4)
                    issue(next_load());
                else
                    issue(random_tick());
                sent++;
            end
            phase++;
        end

        // Make sure the table is full, late tasks included, so further loads are rejected.
        wait_drained();
        while (n_loaded < MAX_TASKS)
            issue(next_load());

        // A closing stretch with neither the sender nor the receiver idling.
        wait_drained();
        write_key(1'($urandom_range(0, 1)));
        no_idle = 1'b1;
        repeat (NO_IDLE_ITEMS)
        begin
            if ($urandom_range(0, 99) < 3)
                issue(next_load());
            else
                issue(random_tick());
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (MAX_TASKS + 8) @(negedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
